### hw/rtl/adam_optimizer_update_top_macros.svh
// ----------------------------------------------------------------------------
// adam optimizer update assertion macros
// shorthand for clocked implication checks used in the rtl
// ----------------------------------------------------------------------------
`ifndef ADAM_OPTIMIZER_UPDATE_TOP_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define AOU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AOU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/aou_pkg.sv
// ----------------------------------------------------------------------------
// aou_pkg
// shared widths, types and saturation helpers of the adam update engine
// ----------------------------------------------------------------------------
package aou_pkg;

  localparam int unsigned NumParamsDef = 1024;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned DataW        = 32;
  localparam int unsigned LrW          = 25;
  localparam int unsigned BetaW        = 16;
  localparam int unsigned PowW         = 33;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 25;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned DivNumW      = 64;
  localparam int unsigned DivDenW      = 33;
  localparam int unsigned DivQuoW      = 33;
  localparam int unsigned SqrtInW      = 56;
  localparam int unsigned RootW        = 28;
  localparam int unsigned DenW         = 29;

  localparam logic [LrW-1:0]   LrReset    = 25'd16777;
  localparam logic [BetaW-1:0] Beta1Reset = 16'd58982;
  localparam logic [BetaW-1:0] Beta2Reset = 16'd65470;
  localparam logic [LrW-1:0]   EpsReset   = 25'd1;
  localparam logic [PowW-1:0]  OneQ32     = 33'h1_0000_0000;

  localparam logic signed [DataW-1:0] SMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] SMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LR    = 2'd0,
    REG_BETA1 = 2'd1,
    REG_BETA2 = 2'd2,
    REG_EPS   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [LrW-1:0]   lr;
    logic [BetaW-1:0] beta1;
    logic [BetaW-1:0] beta2;
    logic [LrW-1:0]   eps;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic                    in_range;
    logic signed [DataW-1:0] gradient;
    logic signed [DataW-1:0] weight;
    logic [PowW-1:0]         d1;
    logic [PowW-1:0]         d2;
  } entry_t;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    sat;
  } sat_res_t;

  // signed value from magnitude and sign, saturating
  function automatic sat_res_t sat_mag(input logic [33:0] mag, input logic neg);
    sat_res_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 34'h0_8000_0000) begin
        r.val = SMin;
        r.sat = 1'b1;
      end else begin
        r.val = 32'sd0 - $signed(mag[31:0]);
      end
    end else begin
      if (mag > 34'h0_7FFF_FFFF) begin
        r.val = SMax;
        r.sat = 1'b1;
      end else begin
        r.val = $signed(mag[31:0]);
      end
    end
    return r;
  endfunction

  function automatic sat_res_t clamp_s35(input logic signed [34:0] x);
    sat_res_t r;
    r.sat = 1'b0;
    if (x > 35'sd2147483647) begin
      r.val = SMax;
      r.sat = 1'b1;
    end else if (x < -35'sd2147483648) begin
      r.val = SMin;
      r.sat = 1'b1;
    end else begin
      r.val = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

### hw/rtl/aou_fifo.sv
// ----------------------------------------------------------------------------
// aou_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module aou_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aou_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output aou_pkg::entry_t data_o
);
  import aou_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/aou_front.sv
// ----------------------------------------------------------------------------
// aou_front
// config registers, decay powers and item intake into the queue
// ----------------------------------------------------------------------------
module aou_front #(
  parameter int unsigned NUM_PARAMS = aou_pkg::NumParamsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [aou_pkg::IdxW-1:0]      param_index_i,
  input  logic signed [aou_pkg::DataW-1:0] gradient_i,
  input  logic signed [aou_pkg::DataW-1:0] weight_i,
  input  logic                          new_step_i,
  input  logic                          cfg_we_i,
  input  logic [aou_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [aou_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          init_done_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output aou_pkg::entry_t               q_data_o,
  output aou_pkg::cfg_t                 cfg_o
);
  import aou_pkg::*;

  cfg_t            cfg_q;
  logic [PowW-1:0] p1_q, p2_q, p1_nx, p2_nx;
  logic [48:0]     p1_mul, p2_mul;

  assign full_o   = q_full_i || !init_done_i;
  assign q_push_o = push_i && !full_o;
  assign cfg_o    = cfg_q;

  assign p1_mul = p1_q * cfg_q.beta1;
  assign p2_mul = p2_q * cfg_q.beta2;
  assign p1_nx  = new_step_i ? p1_mul[48:16] : p1_q;
  assign p2_nx  = new_step_i ? p2_mul[48:16] : p2_q;

  always_comb begin
    q_data_o.idx      = param_index_i;
    q_data_o.in_range = (32'(param_index_i) < NUM_PARAMS);
    q_data_o.gradient = gradient_i;
    q_data_o.weight   = weight_i;
    q_data_o.d1       = OneQ32 - p1_nx;
    q_data_o.d2       = OneQ32 - p2_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr    <= LrReset;
      cfg_q.beta1 <= Beta1Reset;
      cfg_q.beta2 <= Beta2Reset;
      cfg_q.eps   <= EpsReset;
      p1_q        <= OneQ32;
      p2_q        <= OneQ32;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_LR:    cfg_q.lr    <= cfg_wdata_i;
          REG_BETA1: cfg_q.beta1 <= cfg_wdata_i[BetaW-1:0];
          REG_BETA2: cfg_q.beta2 <= cfg_wdata_i[BetaW-1:0];
          REG_EPS:   cfg_q.eps   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (q_push_o) begin
        p1_q <= p1_nx;
        p2_q <= p2_nx;
      end
    end
  end

endmodule

### hw/rtl/aou_div.sv
// ----------------------------------------------------------------------------
// aou_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aou_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [aou_pkg::DivNumW-1:0]   num_i,
  input  logic [aou_pkg::DivDenW-1:0]   den_i,
  output logic                          done_o,
  output logic [aou_pkg::DivQuoW-1:0]   quo_o
);
  import aou_pkg::*;

  localparam int unsigned CntW = $clog2(DivQuoW);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DivDenW-1:0]  rem_q, den_q;
  logic [DivQuoW-1:0]  num_q, quo_q;
  logic [DivDenW:0]    trial, diff;
  logic                ge;

  // valid only while the quotient fits, the caller checks that
  assign trial = {rem_q, num_q[DivQuoW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(DivQuoW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(DivQuoW - 1)) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DivDenW'(num_i[DivNumW-1:DivQuoW]);
      num_q <= num_i[DivQuoW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[DivQuoW-2:0], ge};
    end
  end

endmodule

### hw/rtl/aou_sqrt.sv
// ----------------------------------------------------------------------------
// aou_sqrt
// digit-by-digit integer square root of a q8.24 value, one bit per cycle
// ----------------------------------------------------------------------------
module aou_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [aou_pkg::DataW-1:0]   radicand_i,
  output logic                        done_o,
  output logic [aou_pkg::RootW-1:0]   root_o
);
  import aou_pkg::*;

  localparam int unsigned CntW    = $clog2(RootW);
  localparam int unsigned RadFrac = SqrtInW - DataW;

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [SqrtInW-1:0]  x_q;
  logic [RootW+1:0]    rem_q;
  logic [RootW-1:0]    root_q;
  logic [RootW+3:0]    r4, trial, diff;
  logic                ge;

  assign r4    = {rem_q, x_q[SqrtInW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = r4 >= trial;
  assign diff  = r4 - trial;

  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(RootW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= {radicand_i, RadFrac'(0)};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      rem_q  <= ge ? diff[RootW+1:0] : r4[RootW+1:0];
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

endmodule

### hw/rtl/aou_back.sv
// ----------------------------------------------------------------------------
// aou_back
// moment stores, bias correction and weight update sequencer
// ----------------------------------------------------------------------------
`include "adam_optimizer_update_top_macros.svh"

module aou_back #(
  parameter int unsigned NUM_PARAMS = aou_pkg::NumParamsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  aou_pkg::entry_t                  q_data_i,
  output logic                             q_pop_o,
  input  aou_pkg::cfg_t                    cfg_i,
  input  logic                             pop_i,
  output logic                             res_valid_o,
  output logic [aou_pkg::IdxW-1:0]         res_index_o,
  output logic signed [aou_pkg::DataW-1:0] res_weight_o,
  output logic                             res_sat_o,
  output logic                             init_done_o
);
  import aou_pkg::*;

  localparam int unsigned AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_MUL, S_MOM, S_DSTART, S_DIV1,
    S_SQGO, S_SQRT, S_PROD, S_DGO, S_DIV2, S_DONE
  } state_e;

  state_e  state_q;
  logic [AW-1:0] clr_q;
  logic    res_valid_q, init_done_q;

  logic signed [DataW-1:0] m_mem [NUM_PARAMS];
  logic [DataW-1:0]        v_mem [NUM_PARAMS];

  entry_t                  ent_q;
  logic signed [DataW-1:0] m_rd_q, m_q, mhat_q, upd_q;
  logic [DataW-1:0]        v_rd_q, v_q, vhat_q;
  logic [63:0]             gsq_prod_q;
  logic signed [48:0]      pm1_q;
  logic signed [49:0]      pm2_q;
  logic [47:0]             pv1_q;
  logic [48:0]             pv2_q;
  logic                    sat_q;
  logic [DenW-1:0]         den_q;
  logic [56:0]             prod_q;
  logic [IdxW-1:0]         res_idx_q;
  logic signed [DataW-1:0] res_w_q;
  logic                    res_sat_q;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic signed [DataW-1:0] mem_wm;
  logic [DataW-1:0]        mem_wv;

  logic [DataW-1:0]        gmag, gsq_s, mmag, mmag2, v_new, vh_val;
  logic                    gsq_ovf, v_ovf, vh_sat, mneg, mneg2, ovf2;
  logic signed [16:0]      b1s;
  logic signed [17:0]      c1s;
  logic [16:0]             c2;
  logic signed [50:0]      msum;
  logic signed [34:0]      msh, ndiff;
  logic [49:0]             vsum;
  logic [33:0]             vsh;
  sat_res_t                mcl, mh, up, nw;

  logic                    div_a_start, div_b_start, div_a_done, div_b_done;
  logic [DivNumW-1:0]      div_a_num, div_b_num;
  logic [DivDenW-1:0]      div_a_den;
  logic [DivQuoW-1:0]      quo_a, quo_b;
  logic                    sq_start, sq_done;
  logic [RootW-1:0]        sq_root;
  logic                    res_free;

  aou_div u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_a_start),
    .num_i   (div_a_num),
    .den_i   (div_a_den),
    .done_o  (div_a_done),
    .quo_o   (quo_a)
  );

  aou_div u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_b_start),
    .num_i   (div_b_num),
    .den_i   (ent_q.d2),
    .done_o  (div_b_done),
    .quo_o   (quo_b)
  );

  aou_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (vhat_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign res_free    = !res_valid_q || pop_i;
  assign res_valid_o = res_valid_q;
  assign res_index_o = res_idx_q;
  assign res_weight_o = res_w_q;
  assign res_sat_o   = res_sat_q;
  assign init_done_o = init_done_q;

  assign div_a_start = (state_q == S_DSTART) || (state_q == S_DGO);
  assign div_b_start = (state_q == S_DSTART);
  assign sq_start    = (state_q == S_SQGO);
  assign div_a_num   = (state_q == S_DGO) ? {7'b0, prod_q} : {mmag, 32'b0};
  assign div_a_den   = (state_q == S_DGO) ? {4'b0, den_q} : ent_q.d1;
  assign div_b_num   = {v_q, 32'b0};

  always_comb begin
    // gradient square and moment sums
    gmag    = ent_q.gradient[DataW-1] ? (~ent_q.gradient + 32'd1) : ent_q.gradient;
    gsq_ovf = |gsq_prod_q[63:56];
    gsq_s   = gsq_ovf ? '1 : gsq_prod_q[55:24];
    b1s     = {1'b0, cfg_i.beta1};
    c1s     = {1'b0, 17'h1_0000 - {1'b0, cfg_i.beta1}};
    c2      = 17'h1_0000 - {1'b0, cfg_i.beta2};
    msum    = pm1_q + pm2_q;
    msh     = msum[50:16];
    mcl     = clamp_s35(msh);
    vsum    = pv1_q + pv2_q;
    vsh     = vsum[49:16];
    v_ovf   = |vsh[33:32];
    v_new   = v_ovf ? '1 : vsh[31:0];

    // bias corrected first moment
    mneg = m_q[DataW-1];
    mmag = mneg ? (~m_q + 32'd1) : m_q;
    if (ent_q.d1 == '0) begin
      mh.sat = 1'b1;
      mh.val = (mmag == '0) ? '0 : (mneg ? SMin : SMax);
    end else if ({1'b0, mmag} >= ent_q.d1) begin
      mh.sat = 1'b1;
      mh.val = mneg ? SMin : SMax;
    end else begin
      mh = sat_mag({1'b0, quo_a}, mneg);
    end

    // bias corrected second moment
    if (ent_q.d2 == '0) begin
      vh_sat = 1'b1;
      vh_val = (v_q == '0) ? '0 : '1;
    end else if ({1'b0, v_q} >= ent_q.d2) begin
      vh_sat = 1'b1;
      vh_val = '1;
    end else begin
      vh_sat = 1'b0;
      vh_val = quo_b[DataW-1:0];
    end

    // step size times corrected moment over denominator
    mneg2 = mhat_q[DataW-1];
    mmag2 = mneg2 ? (~mhat_q + 32'd1) : mhat_q;
    ovf2  = {5'b0, prod_q} >= {den_q, 33'b0};
    if (den_q == '0) begin
      up.sat = 1'b1;
      up.val = (mmag2 == '0) ? '0 : (mneg2 ? SMin : SMax);
    end else if (ovf2) begin
      up.sat = 1'b1;
      up.val = mneg2 ? SMin : SMax;
    end else begin
      up = sat_mag({1'b0, quo_a}, mneg2);
    end

    ndiff = 35'(ent_q.weight) - 35'(upd_q);
    nw    = clamp_s35(ndiff);

    mem_we    = (state_q == S_CLEAR) || (state_q == S_MOM);
    mem_waddr = (state_q == S_CLEAR) ? clr_q : AW'(ent_q.idx);
    mem_wm    = (state_q == S_CLEAR) ? '0 : mcl.val;
    mem_wv    = (state_q == S_CLEAR) ? '0 : v_new;
    mem_raddr = AW'(ent_q.idx);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      m_mem[mem_waddr] <= mem_wm;
      v_mem[mem_waddr] <= mem_wv;
    end
    m_rd_q <= m_mem[mem_raddr];
    v_rd_q <= v_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      init_done_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && res_free) begin
        res_valid_q <= 1'b1;
      end else if (pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(NUM_PARAMS - 1)) begin
            init_done_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= q_data_i.in_range ? S_READ : S_DONE;
          end
        end
        S_READ:   state_q <= S_MUL;
        S_MUL:    state_q <= S_MOM;
        S_MOM:    state_q <= S_DSTART;
        S_DSTART: state_q <= S_DIV1;
        S_DIV1: begin
          if (div_a_done && div_b_done) begin
            state_q <= S_SQGO;
          end
        end
        S_SQGO: state_q <= S_SQRT;
        S_SQRT: begin
          if (sq_done) begin
            state_q <= S_PROD;
          end
        end
        S_PROD: state_q <= S_DGO;
        S_DGO:  state_q <= S_DIV2;
        S_DIV2: begin
          if (div_a_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ent_q <= q_data_i;
        sat_q <= 1'b0;
        upd_q <= '0;
      end
      S_READ: gsq_prod_q <= gmag * gmag;
      S_MUL: begin
        pm1_q <= b1s * m_rd_q;
        pm2_q <= c1s * ent_q.gradient;
        pv1_q <= cfg_i.beta2 * v_rd_q;
        pv2_q <= c2 * gsq_s;
        sat_q <= sat_q | gsq_ovf;
      end
      S_MOM: begin
        m_q   <= mcl.val;
        v_q   <= v_new;
        sat_q <= sat_q | mcl.sat | v_ovf;
      end
      S_DIV1: begin
        if (div_a_done) begin
          mhat_q <= mh.val;
          vhat_q <= vh_val;
          sat_q  <= sat_q | mh.sat | vh_sat;
        end
      end
      S_PROD: begin
        den_q  <= DenW'(sq_root) + DenW'(cfg_i.eps);
        prod_q <= cfg_i.lr * mmag2;
      end
      S_DIV2: begin
        if (div_a_done) begin
          upd_q <= up.val;
          sat_q <= sat_q | up.sat;
        end
      end
      S_DONE: begin
        if (res_free) begin
          res_idx_q <= ent_q.idx;
          res_w_q   <= ent_q.in_range ? nw.val : ent_q.weight;
          res_sat_q <= ent_q.in_range ? (sat_q | nw.sat) : 1'b0;
        end
      end
      default: ;
    endcase
  end

  `AOU_ASSERT_NXT(a_res_hold, res_valid_q && !pop_i, res_valid_q && $stable(res_w_q), "result changed before it was taken")
  `AOU_ASSERT_IMP(a_no_take_in_clear, !init_done_q, !q_pop_o && (state_q == S_CLEAR), "item taken during clearing pass")
  `AOU_ASSERT_IMP(a_div_done_wait, div_a_done, (state_q == S_DIV1) || (state_q == S_DIV2), "divider finished outside a wait state")
  `AOU_ASSERT_IMP(a_mem_write, mem_we && init_done_q, state_q == S_MOM, "moment store written outside the update state")

endmodule

### hw/rtl/adam_optimizer_update_top.sv
// ----------------------------------------------------------------------------
// adam_optimizer_update_top
// fixed point adam update engine with per-parameter moment stores
// ----------------------------------------------------------------------------
// usage:
// items enter through a queue style port: push with full, one item per edge
// where push is high and full low; each item carries index, gradient, weight
// and a new_step flag that advances the decay powers before the update.
// results leave through empty and pop: the oldest result sits on the ports
// while empty is low and is taken at an edge where pop is high.
// each item in the back end runs two passes through a restoring divider
// and one square root in series, plus handshake, memory read, products
// and moment update. a two-entry queue in front lets up to two more
// items be taken meanwhile. after reset the moment stores are swept to
// zero and full stays high until the sweep ends; config writes are taken
// any time. when the receiver holds off pop the finished result waits in
// its output register, the back end stalls before writing the next one
// and full rises once the queue fills.
// ----------------------------------------------------------------------------
module adam_optimizer_update_top #(
  parameter int unsigned NUM_PARAMS = aou_pkg::NumParamsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [aou_pkg::IdxW-1:0]         param_index_i,
  input  logic signed [aou_pkg::DataW-1:0] gradient_i,
  input  logic signed [aou_pkg::DataW-1:0] weight_i,
  input  logic                             new_step_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [aou_pkg::IdxW-1:0]         out_index_o,
  output logic signed [aou_pkg::DataW-1:0] new_weight_o,
  output logic                             saturated_o,
  input  logic                             cfg_we_i,
  input  logic [aou_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [aou_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import aou_pkg::*;

  entry_t q_in, q_out;
  cfg_t   cfg;
  logic   q_push, q_full, q_pop, q_empty, init_done, res_valid;

  aou_front #(
    .NUM_PARAMS (NUM_PARAMS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .param_index_i (param_index_i),
    .gradient_i    (gradient_i),
    .weight_i      (weight_i),
    .new_step_i    (new_step_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .init_done_i   (init_done),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_in),
    .cfg_o         (cfg)
  );

  aou_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  aou_back #(
    .NUM_PARAMS (NUM_PARAMS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .cfg_i        (cfg),
    .pop_i        (pop),
    .res_valid_o  (res_valid),
    .res_index_o  (out_index_o),
    .res_weight_o (new_weight_o),
    .res_sat_o    (saturated_o),
    .init_done_o  (init_done)
  );

  assign empty = !res_valid;

endmodule

### dv/adam_optimizer_update_top_test.sv
// ----------------------------------------------------------------------------
// adam_optimizer_update_top_test
// checks the fixed point adam update engine against an in-bench predictor:
// directed extremes and zero-denominator cases, then optimizer steps over
// small parameter sets under several register settings, with random gaps
// on the push side and random stalls on the pop side
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module adam_optimizer_update_top_test;
  import aou_pkg::*;

  localparam int unsigned NParams    = NumParamsDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 250;

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] gradient;
    logic signed [DataW-1:0] weight;
    logic                    new_step;
  } update_item_t;

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] new_weight;
    logic                    saturated;
  } update_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic [IdxW-1:0]         param_index_i = '0;
  logic signed [DataW-1:0] gradient_i = '0;
  logic signed [DataW-1:0] weight_i = '0;
  logic                    new_step_i = 1'b0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [IdxW-1:0]         out_index_o;
  logic signed [DataW-1:0] new_weight_o;
  logic                    saturated_o;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_wdata_i = '0;

  adam_optimizer_update_top dut (
    .clk_i, .rst_ni, .push, .full, .param_index_i, .gradient_i, .weight_i,
    .new_step_i, .empty, .pop, .out_index_o, .new_weight_o, .saturated_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned learn_rate, decay1, decay2, guard, pow1, pow2;
  int              m_store[NParams];
  int unsigned     v_store[NParams];

  update_result_t expected_weights[$];
  int unsigned    errors = 0;
  int unsigned    items_sent = 0;
  int unsigned    results_seen = 0;
  int unsigned    sat_seen = 0;
  int unsigned    cycles = 0;
  bit             no_idle = 1'b0;
  bit             pop_taken = 1'b0;
  int unsigned    pop_stall = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
  endtask

  function automatic longint clamp_s32(input longint x, inout bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint mag_to_s32(input longint unsigned mag, input bit neg, inout bit sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(mag);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic update_result_t predict_update(input update_item_t it);
    update_result_t  r;
    bit              sat, mneg;
    longint          g, w, m, mhat, upd, nw, b1, b2;
    longint unsigned gmag, gsq, v, d1, d2, mmag, vhat, den;
    sat = 1'b0;
    g = longint'(it.gradient);
    w = longint'(it.weight);
    nw = w;
    if (it.new_step) begin
      pow1 = (pow1 * decay1) >> 16;
      pow2 = (pow2 * decay2) >> 16;
    end
    if (it.idx < NParams) begin
      b1 = longint'(decay1);
      b2 = longint'(decay2);
      m = longint'(m_store[it.idx]);
      v = longint'(v_store[it.idx]);
      gmag = (g < 0) ? longint'(-g) : longint'(g);
      gsq = (gmag * gmag) >> 24;
      if (gsq > 64'hFFFF_FFFF) begin
        gsq = 64'hFFFF_FFFF;
        sat = 1'b1;
      end
      m = clamp_s32((b1 * m + (65536 - b1) * g) >>> 16, sat);
      v = (decay2 * v + (65536 - decay2) * gsq) >> 16;
      if (v > 64'hFFFF_FFFF) begin
        v = 64'hFFFF_FFFF;
        sat = 1'b1;
      end
      m_store[it.idx] = int'(m);
      v_store[it.idx] = v[31:0];
      d1 = ((64'd1 << 32) - pow1) & 64'h1_FFFF_FFFF;
      d2 = ((64'd1 << 32) - pow2) & 64'h1_FFFF_FFFF;
      mneg = m < 0;
      mmag = mneg ? longint'(-m) : longint'(m);
      // bias denominator zero while a power is still one
      if (d1 == 0) begin
        sat = 1'b1;
        mhat = (mmag == 0) ? 0 : (mneg ? -64'sd2147483648 : 64'sd2147483647);
      end else begin
        mhat = mag_to_s32((mmag << 32) / d1, mneg, sat);
      end
      if (d2 == 0) begin
        sat = 1'b1;
        vhat = (v == 0) ? 0 : 64'hFFFF_FFFF;
      end else begin
        vhat = (v << 32) / d2;
        if (vhat > 64'hFFFF_FFFF) begin
          vhat = 64'hFFFF_FFFF;
          sat = 1'b1;
        end
      end
      den = int_sqrt(vhat << 24) + guard;
      mneg = mhat < 0;
      mmag = mneg ? longint'(-mhat) : longint'(mhat);
      if (den == 0) begin
        sat = 1'b1;
        upd = (mmag == 0) ? 0 : (mneg ? -64'sd2147483648 : 64'sd2147483647);
      end else begin
        upd = mag_to_s32((learn_rate * mmag) / den, mneg, sat);
      end
      nw = clamp_s32(w - upd, sat);
    end
    r.idx = it.idx;
    r.new_weight = nw[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // result side: compare while the item is stable, take it at the next edge
  always @(negedge clk_i) begin
    update_result_t want;
    if (rst_ni && pop && !empty) begin
      pop_taken = 1'b1;
      if (expected_weights.size() == 0) begin
        report_mismatch("result with nothing expected, index", out_index_o, 0);
      end else begin
        want = expected_weights.pop_front();
        if (out_index_o !== want.idx) report_mismatch("out_index", out_index_o, want.idx);
        if (new_weight_o !== want.new_weight)
          report_mismatch("new_weight", new_weight_o, want.new_weight);
        if (saturated_o !== want.saturated)
          report_mismatch("saturated", saturated_o, want.saturated);
        if (want.saturated) sat_seen++;
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** adam_optimizer_update_top: FAILED **");
      $finish;
    end
    if (pop_taken) begin
      pop_taken = 1'b0;
      pop_stall = (no_idle || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 15);
    end
    if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni;
    end
  end

  // called at a rising edge, returns at the edge where the item is taken
  task automatic send_item(input update_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    param_index_i <= it.idx;
    gradient_i <= it.gradient;
    weight_i <= it.weight;
    new_step_i <= it.new_step;
    forever begin
      @(negedge clk_i);
      if (!full) break;
    end
    @(posedge clk_i);
    expected_weights = {expected_weights, predict_update(it)};
    items_sent++;
  endtask

  task automatic send_fields(input int idx, input int g, input int w, input bit ns);
    update_item_t it;
    it.idx = IdxW'(idx);
    it.gradient = g;
    it.weight = w;
    it.new_step = ns;
    send_item(it);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // one write per call; the enable is low again before the task returns
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LR:    learn_rate = 64'(value);
      REG_BETA1: decay1 = 64'(value[BetaW-1:0]);
      REG_BETA2: decay2 = 64'(value[BetaW-1:0]);
      REG_EPS:   guard = 64'(value);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [CfgDataW-1:0] lr, input logic [CfgDataW-1:0] b1,
                           input logic [CfgDataW-1:0] b2, input logic [CfgDataW-1:0] eps);
    write_reg(REG_LR, lr);
    write_reg(REG_BETA1, b1);
    write_reg(REG_BETA2, b2);
    write_reg(REG_EPS, eps);
  endtask

  // before any new_step both powers are one, bias denominators are zero
  task automatic test_powers_at_one();
    send_fields(5, 32'sh0100_0000, 32'sh0200_0000, 1'b0);
    send_fields(6, 0, 32'sh7FFF_FFFF, 1'b0);
    send_fields(7, -32'sh0080_0000, -32'sh0100_0000, 1'b0);
    drain_results();
  endtask

  task automatic test_field_extremes();
    send_fields(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_fields(1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_fields(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_fields(1023, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_fields(512, 0, 0, 1'b1);
    send_fields(511, -1, -1, 1'b0);
    send_fields(512, 1, 1, 1'b1);
    drain_results();
  endtask

  // root and epsilon both zero: tiny gradient leaves the second moment at zero
  task automatic test_zero_update_den();
    write_all(25'h1FF_FFFF, 0, 25'h1AB_0000, 0);
    send_fields(100, 100, 32'sh0100_0000, 1'b1);
    send_fields(101, -200, 32'sh0100_0000, 1'b0);
    send_fields(102, 0, 32'sh0100_0000, 1'b0);
    send_fields(100, 32'sh0001_0000, 32'sh7FFF_0000, 1'b1);
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_all(25'd16777216, 65535, 65535, 25'd16777216);
    send_fields(200, 32'sh0400_0000, 0, 1'b1);
    send_fields(201, -32'sh0400_0000, 0, 1'b0);
    drain_results();
    write_all(0, 0, 0, 25'h1FF_FFFF);
    send_fields(200, 32'sh0400_0000, 32'sh1234_5678, 1'b1);
    send_fields(202, 32'sh7000_0000, 32'sh8000_0001, 1'b0);
    drain_results();
  endtask

  function automatic int rand_gradient();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h0FFF)) - 32'sh0800;
      default: return $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
    endcase
  endfunction

  // optimizer steps over a small parameter set, some noise items mixed in
  task automatic run_steps(input int unsigned n_items);
    int unsigned base, span, count, k;
    update_item_t it;
    base = $urandom_range(0, NParams - 1);
    span = $urandom_range(1, 12);
    count = 0;
    while (count < n_items) begin
      no_idle = ($urandom_range(0, 3) == 0);
      k = $urandom_range(1, 8);
      for (int unsigned j = 0; j < k && count < n_items; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          it.idx = IdxW'($urandom());
          it.new_step = $urandom_range(0, 1) == 1;
        end else begin
          it.idx = IdxW'((base + $urandom_range(0, span - 1)) % NParams);
          it.new_step = (j == 0);
        end
        it.gradient = rand_gradient();
        it.weight = $urandom();
        send_item(it);
        count++;
      end
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic test_random_settings();
    write_all(CfgDataW'(LrReset), CfgDataW'(Beta1Reset), CfgDataW'(Beta2Reset),
              CfgDataW'(EpsReset));
    run_steps(120);
    write_all(CfgDataW'($urandom_range(0, 25'd16777216)), CfgDataW'($urandom()),
              CfgDataW'($urandom()), CfgDataW'($urandom_range(0, 4096)));
    run_steps(120);
    write_all(25'd16777216, CfgDataW'($urandom_range(32768, 65535)),
              CfgDataW'($urandom_range(60000, 65535)), 0);
    run_steps(120);
    write_all(CfgDataW'($urandom()), CfgDataW'($urandom()), CfgDataW'($urandom()),
              CfgDataW'($urandom()));
    run_steps(120);
  endtask

  initial begin
    learn_rate = 64'(LrReset);
    decay1 = 64'(Beta1Reset);
    decay2 = 64'(Beta2Reset);
    guard = 64'(EpsReset);
    pow1 = 64'd1 << 32;
    pow2 = 64'd1 << 32;
    for (int i = 0; i < NParams; i++) begin
      m_store[i] = 0;
      v_store[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_powers_at_one();
    test_field_extremes();
    test_zero_update_den();
    test_register_extremes();
    test_random_settings();
    if (expected_weights.size() != 0) begin
      report_mismatch("results pending at end", expected_weights.size(), 0);
    end
    $display("sent %0d items, checked %0d results, %0d of them saturated",
             items_sent, results_seen, sat_seen);
    $display("covered unit powers, zero denominators and seven register settings");
    if (errors == 0) begin
      $display("** adam_optimizer_update_top: PASSED **");
    end else begin
      $display("** adam_optimizer_update_top: FAILED **");
    end
    $finish;
  end

endmodule
